FILE: rtl/assert_macros.svh
// Assertion macros used by the saturator core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds in the same cycle as the trigger.
`define STS_ASSERT_NOW(lbl, trig, cond) \
   lbl: assert property (@(posedge clock) disable iff (reset) (trig) |-> (cond)) \
      else $error("assertion failed");

// Condition holds in the cycle after the trigger.
`define STS_ASSERT_NEXT(lbl, trig, cond) \
   lbl: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cond)) \
      else $error("assertion failed");

`endif

FILE: rtl/sts_pkg.sv
// Types, constants and the tanh table for the stereo saturator.
package sts_pkg;

   localparam int SAMPLE_BITS    = 24;
   localparam int TANH_ENTRIES   = 256;
   localparam int TANH_IDX_BITS  = $clog2(TANH_ENTRIES);
   localparam int TANH_ADDR_BITS = $clog2(TANH_ENTRIES + 1);
   localparam int TH_BITS        = 24;
   localparam int GAIN_BITS      = 24;
   localparam int LEVEL_BITS     = 24;
   localparam int CFG_BITS       = 16;
   localparam int CFG_SHIFT      = GAIN_BITS - CFG_BITS;
   localparam int FRAC_BITS      = 16;
   localparam int MUL_BITS       = 26;
   localparam int PROD_BITS      = 2 * MUL_BITS;
   localparam int GAIN_FRAC      = 22;
   // prod = |sample| * gain carries SAMPLE_BITS-1+GAIN_FRAC fraction bits
   localparam int IDX_LSB        = SAMPLE_BITS - 1 + GAIN_FRAC + 2 - TANH_IDX_BITS;
   localparam int OVER_LSB       = IDX_LSB + TANH_IDX_BITS;
   localparam int MAG_SHIFT      = 47 - SAMPLE_BITS;
   localparam int SMOOTH_SHIFT   = 16;
   localparam int DATA_BITS      = ((2 * SAMPLE_BITS + 7) / 8) * 8;

   localparam logic [MUL_BITS-1:0]       SMOOTH_COEF  = MUL_BITS'(3277);
   localparam logic [GAIN_BITS-1:0]      GAIN_RESET   = GAIN_BITS'(4194304);
   localparam logic [LEVEL_BITS-1:0]     LEVEL_RESET  = LEVEL_BITS'(8388608);
   localparam logic [CFG_BITS-1:0]       DRIVE_RESET  = CFG_BITS'(16384);
   localparam logic [CFG_BITS-1:0]       OUTPUT_RESET = CFG_BITS'(32768);
   localparam logic [GAIN_BITS-1:0]      GAIN_MAX     = {{CFG_BITS{1'b1}}, {CFG_SHIFT{1'b0}}};
   localparam logic [TANH_ADDR_BITS-1:0] TANH_LAST    = TANH_ADDR_BITS'(TANH_ENTRIES);

   typedef enum logic [1:0] {
      CSR_DRIVE_GAIN   = 2'd0,
      CSR_OUTPUT_LEVEL = 2'd1,
      CSR_BYPASS       = 2'd2
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SM_GAIN,
      ST_SM_LEVEL,
      ST_SM_APPLY,
      ST_CH_SCALE,
      ST_CH_INDEX,
      ST_CH_READ_B,
      ST_CH_INTERP,
      ST_CH_BLEND,
      ST_CH_MAG,
      ST_CH_ROUND,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic signed [MUL_BITS-1:0] op_a;
      logic signed [MUL_BITS-1:0] op_b;
   } mul_req_type;

   typedef logic [TANH_ENTRIES:0][TH_BITS-1:0] tanh_table_type;

   // Shift-subtract quotient, used only while building the table.
   function automatic logic [63:0] long_quot(input logic [63:0] num, input logic [63:0] den);
      logic [64:0] rem;
      logic [63:0] quo;
      rem = '0;
      quo = '0;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[63:0], num[b]};
         if (rem >= {1'b0, den}) begin
            rem    = rem - {1'b0, den};
            quo[b] = 1'b1;
         end
      end
      return quo;
   endfunction

   // tanh(4*i/TANH_ENTRIES) in Q0.23 as (1-e)/(1+e), e = exp(-8*i/TANH_ENTRIES) in Q30.
   function automatic logic [TH_BITS-1:0] tanh_entry(input logic [63:0] i);
      logic [63:0] one;
      logic [63:0] y;
      logic [63:0] z;
      logic [63:0] term;
      logic [63:0] sum;
      logic [63:0] e;
      one  = 64'd1 << 30;
      y    = long_quot((64'd8 * i) << 30, 64'(TANH_ENTRIES));
      z    = y >> 4;
      term = one;
      sum  = one;
      for (int k = 1; k <= 14; k++) begin
         term = long_quot((term * z) >> 30, 64'(k));
         if (k % 2 == 1) sum = sum - term;
         else            sum = sum + term;
      end
      e = sum;
      for (int k = 0; k < 4; k++) e = (e * e + (64'd1 << 29)) >> 30;
      if (e > one) e = one;
      return TH_BITS'(long_quot(((one - e) << 23) + ((one + e) >> 1), one + e));
   endfunction

   function automatic tanh_table_type build_tanh_table();
      tanh_table_type t;
      for (int i = 0; i <= TANH_ENTRIES; i++) t[i] = tanh_entry(64'(i));
      return t;
   endfunction

   localparam tanh_table_type TANH_TABLE = build_tanh_table();

endpackage

FILE: rtl/stereo_tanh_saturator_core.sv
// Top level of the stereo tanh saturator with smoothed drive and level.
//
//   port group | direction | contents
//   req_*      | in        | one stereo frame per transfer
//   rsp_*      | out       | one processed frame per input frame
//   csr_*      | in        | write-only registers: drive gain, output level, bypass
//
// A frame runs the smoothing steps and, unless bypassed, the table steps of each channel
// before its result stands in the output register; no new frame is taken until then, and
// the shared multiplier and the table read port serve at most one operation a step.
// Reset is synchronous and restores the smoothers and registers; no clearing pass is needed.
// req_tready is high only when the sequencer is idle; a stalled result holds the sequencer
// in its last step until the output register is free.
module stereo_tanh_saturator_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [sts_pkg::DATA_BITS-1:0]    req_tdata,  // left_sample, right_sample
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [sts_pkg::DATA_BITS-1:0]    rsp_tdata,  // left_result, right_result
   input  logic                             csr_we,
   input  logic [1:0]                       csr_index,
   input  logic [sts_pkg::CFG_BITS-1:0]     csr_wdata
);
   import sts_pkg::*;

   `include "assert_macros.svh"

   state_type state_ff, state_in;

   logic [CFG_BITS-1:0]    drive_ff, level_tgt_ff;
   logic                   bypass_ff;
   logic [GAIN_BITS-1:0]   gain_ff, gain_in;
   logic [LEVEL_BITS-1:0]  level_ff, level_in;
   logic [SAMPLE_BITS-1:0] left_ff, left_in, right_ff, right_in;
   logic [SAMPLE_BITS-1:0] res_left_ff, res_left_in, res_right_ff, res_right_in;
   logic                   ch_ff, ch_in;
   logic [TANH_ADDR_BITS-1:0] addr_ff, addr_in;
   logic [FRAC_BITS-1:0]   frac_ff, frac_in;
   logic                   over_ff, over_in;
   logic [TH_BITS-1:0]     a_ff, a_in, th_ff, th_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [DATA_BITS-1:0]   rsp_data_ff, rsp_data_in;

   mul_req_type                  mul_req;
   logic signed [PROD_BITS-1:0]  prod_ff;
   logic [TANH_ADDR_BITS-1:0]    rom_addr;
   logic [TH_BITS-1:0]           rom_data_ff;

   logic                   req_xfer, rsp_xfer, out_free;
   logic [SAMPLE_BITS-1:0] cur, ax;
   logic                   neg;
   logic signed [GAIN_BITS:0] gain_delta, level_delta;
   logic signed [PROD_BITS-1:0] smooth_rnd, interp_rnd, mag_rnd;
   logic [GAIN_BITS-1:0]   gain_step;
   logic [LEVEL_BITS-1:0]  level_step;
   logic [PROD_BITS-MAG_SHIFT-1:0] mag;
   logic [SAMPLE_BITS-1:0] chan_res;
   logic                   prod_over;
   logic [TANH_IDX_BITS-1:0] prod_idx;

   sts_mul u_mul (
      .clock   (clock),
      .mul_req (mul_req),
      .prod_ff (prod_ff)
   );

   sts_tanh_rom u_rom (
      .clock   (clock),
      .addr    (rom_addr),
      .data_ff (rom_data_ff)
   );

   assign req_xfer = req_tvalid && req_tready;
   assign rsp_xfer = rsp_valid_ff && rsp_tready;
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign cur = ch_ff ? right_ff : left_ff;
   assign neg = cur[SAMPLE_BITS-1];
   assign ax  = neg ? (~cur + 1'b1) : cur;

   assign gain_delta  = $signed({1'b0, drive_ff, {CFG_SHIFT{1'b0}}}) - $signed({1'b0, gain_ff});
   assign level_delta = $signed({1'b0, level_tgt_ff, {CFG_SHIFT{1'b0}}})
                      - $signed({1'b0, level_ff});

   // step = round(delta * 0.05), ties toward plus infinity
   assign smooth_rnd = prod_ff + PROD_BITS'(32768);
   assign gain_step  = GAIN_BITS'(smooth_rnd >>> SMOOTH_SHIFT);
   assign level_step = LEVEL_BITS'(smooth_rnd >>> SMOOTH_SHIFT);

   assign prod_over = |prod_ff[PROD_BITS-1:OVER_LSB];
   assign prod_idx  = prod_ff[OVER_LSB-1:IDX_LSB];

   assign interp_rnd = prod_ff + PROD_BITS'(32768);
   assign mag_rnd    = prod_ff + (PROD_BITS'(1) <<< (MAG_SHIFT - 1));
   assign mag        = mag_rnd[PROD_BITS-1:MAG_SHIFT];

   always_comb begin
      if (neg) begin
         if (mag > (PROD_BITS-MAG_SHIFT)'(1 << (SAMPLE_BITS - 1))) begin
            chan_res = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
         end else begin
            chan_res = ~mag[SAMPLE_BITS-1:0] + 1'b1;
         end
      end else begin
         if (mag > (PROD_BITS-MAG_SHIFT)'((1 << (SAMPLE_BITS - 1)) - 1)) begin
            chan_res = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
         end else begin
            chan_res = mag[SAMPLE_BITS-1:0];
         end
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:      if (req_xfer) state_in = ST_SM_GAIN;
         ST_SM_GAIN:   state_in = ST_SM_LEVEL;
         ST_SM_LEVEL:  state_in = ST_SM_APPLY;
         ST_SM_APPLY:  state_in = bypass_ff ? ST_OUT : ST_CH_SCALE;
         ST_CH_SCALE:  state_in = ST_CH_INDEX;
         ST_CH_INDEX:  state_in = ST_CH_READ_B;
         ST_CH_READ_B: state_in = ST_CH_INTERP;
         ST_CH_INTERP: state_in = ST_CH_BLEND;
         ST_CH_BLEND:  state_in = ST_CH_MAG;
         ST_CH_MAG:    state_in = ST_CH_ROUND;
         ST_CH_ROUND:  state_in = ch_ff ? ST_OUT : ST_CH_SCALE;
         ST_OUT:       if (out_free) state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      req_tready   = (state_ff == ST_IDLE);
      mul_req      = '0;
      rom_addr     = addr_ff;
      gain_in      = gain_ff;
      level_in     = level_ff;
      left_in      = left_ff;
      right_in     = right_ff;
      res_left_in  = res_left_ff;
      res_right_in = res_right_ff;
      ch_in        = ch_ff;
      addr_in      = addr_ff;
      frac_in      = frac_ff;
      over_in      = over_ff;
      a_in         = a_ff;
      th_in        = th_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_xfer;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               left_in  = req_tdata[SAMPLE_BITS-1:0];
               right_in = req_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
            end
         end
         ST_SM_GAIN: begin
            mul_req.op_a = MUL_BITS'(gain_delta);
            mul_req.op_b = SMOOTH_COEF;
         end
         ST_SM_LEVEL: begin
            gain_in      = gain_ff + gain_step;
            mul_req.op_a = MUL_BITS'(level_delta);
            mul_req.op_b = SMOOTH_COEF;
         end
         ST_SM_APPLY: begin
            level_in     = level_ff + level_step;
            ch_in        = 1'b0;
            res_left_in  = left_ff;
            res_right_in = right_ff;
         end
         ST_CH_SCALE: begin
            mul_req.op_a = {{(MUL_BITS-SAMPLE_BITS){1'b0}}, ax};
            mul_req.op_b = {{(MUL_BITS-GAIN_BITS){1'b0}}, gain_ff};
         end
         ST_CH_INDEX: begin
            // beyond the table: hold the end entry
            over_in  = prod_over;
            frac_in  = prod_ff[IDX_LSB-1 -: FRAC_BITS];
            addr_in  = prod_over ? TANH_LAST : TANH_ADDR_BITS'(prod_idx);
            rom_addr = addr_in;
         end
         ST_CH_READ_B: begin
            a_in     = rom_data_ff;
            rom_addr = over_ff ? addr_ff : addr_ff + 1'b1;
         end
         ST_CH_INTERP: begin
            mul_req.op_a = MUL_BITS'($signed({1'b0, rom_data_ff}) - $signed({1'b0, a_ff}));
            mul_req.op_b = {{(MUL_BITS-FRAC_BITS){1'b0}}, frac_ff};
         end
         ST_CH_BLEND: begin
            th_in = over_ff ? a_ff : a_ff + interp_rnd[FRAC_BITS +: TH_BITS];
         end
         ST_CH_MAG: begin
            mul_req.op_a = {{(MUL_BITS-TH_BITS){1'b0}}, th_ff};
            mul_req.op_b = {{(MUL_BITS-LEVEL_BITS){1'b0}}, level_ff};
         end
         ST_CH_ROUND: begin
            if (ch_ff) res_right_in = chan_res;
            else       res_left_in  = chan_res;
            ch_in = 1'b1;
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = DATA_BITS'({res_right_ff, res_left_ff});
            end
         end
         default: begin
            mul_req = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         gain_ff      <= GAIN_RESET;
         level_ff     <= LEVEL_RESET;
         drive_ff     <= DRIVE_RESET;
         level_tgt_ff <= OUTPUT_RESET;
         bypass_ff    <= 1'b0;
         ch_ff        <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         gain_ff      <= gain_in;
         level_ff     <= level_in;
         ch_ff        <= ch_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_DRIVE_GAIN:   drive_ff     <= csr_wdata;
               CSR_OUTPUT_LEVEL: level_tgt_ff <= csr_wdata;
               CSR_BYPASS:       bypass_ff    <= csr_wdata[0];
               default:          bypass_ff    <= bypass_ff;
            endcase
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      left_ff      <= left_in;
      right_ff     <= right_in;
      res_left_ff  <= res_left_in;
      res_right_ff <= res_right_in;
      addr_ff      <= addr_in;
      frac_ff      <= frac_in;
      over_ff      <= over_in;
      a_ff         <= a_in;
      th_ff        <= th_in;
      rsp_data_ff  <= rsp_data_in;
   end

   `STS_ASSERT_NEXT(a_busy_after_accept, req_xfer, !req_tready)
   `STS_ASSERT_NOW(a_gain_in_range, 1'b1, gain_ff <= GAIN_MAX && level_ff <= GAIN_MAX)
   `STS_ASSERT_NEXT(a_result_loaded, state_ff == ST_OUT && out_free, rsp_tvalid && req_tready)

endmodule

FILE: rtl/sts_mul.sv
// Shared signed multiplier with a registered product.
module sts_mul (
   input  logic                          clock,
   input  sts_pkg::mul_req_type          mul_req,
   output logic signed [sts_pkg::PROD_BITS-1:0] prod_ff
);
   import sts_pkg::*;

   logic signed [PROD_BITS-1:0] prod_in;

   assign prod_in = mul_req.op_a * mul_req.op_b;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

FILE: rtl/sts_tanh_rom.sv
// tanh table with a registered read port.
module sts_tanh_rom (
   input  logic                               clock,
   input  logic [sts_pkg::TANH_ADDR_BITS-1:0] addr,
   output logic [sts_pkg::TH_BITS-1:0]        data_ff
);
   import sts_pkg::*;

   logic [TH_BITS-1:0] data_in;

   // addresses past the end entry read the end entry
   assign data_in = (addr > TANH_LAST) ? TANH_TABLE[TANH_ENTRIES] : TANH_TABLE[addr];

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

endmodule
